// ===== hw/rtl/acpd_pkg.sv =====
// Shared constants and types for the ADC polynomial calibration and divider block.
package acpd_pkg;

  // Field and register widths
  localparam int COEF_W    = 48;
  localparam int ACC_W     = 51;
  localparam int CNT_W     = 24;
  localparam int RES_W     = 20;
  localparam int OHM_W     = 32;
  localparam int NUM_COEFS = 7;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;

  // Default parameter values
  localparam int ADC_BITS_DEF       = 12;
  localparam int ADC_FULL_SCALE_DEF = 4095;

  // Divider widths: |cal * R| < 2^43, |full scale - cal| < 2^24
  localparam int PROD_W   = CNT_W + RES_W + 1;
  localparam int DEN_W    = CNT_W + 2;
  localparam int DIV_N_W  = 43;
  localparam int DIV_D_W  = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DEG6 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_RES   = 3'd7;

  // Reset values
  localparam logic signed [COEF_W-1:0] COEF_DEG1_RST = 48'sd268435456;
  localparam logic [RES_W-1:0]         DIV_RES_RST   = 20'd10000;

  // Data carried through the divider pipeline
  typedef struct packed {
    logic [DIV_D_W:0]          rem;
    logic [DIV_N_W-1:0]        work;
    logic [DIV_D_W-1:0]        dvs;
    logic                      neg;
    logic                      derr;
    logic                      sat;
    logic signed [CNT_W-1:0]   cal;
  } div_data_t;

endpackage

// ===== hw/rtl/acpd_horner_step.sv =====
// One Horner step: multiply stage, then floor shift, coefficient add and clamp stage.
module acpd_horner_step #(
  parameter int ADC_BITS = acpd_pkg::ADC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [acpd_pkg::ACC_W-1:0] acc_i,
  input  logic [ADC_BITS-1:0]               sample_i,
  input  logic                              sat_i,
  input  logic signed [acpd_pkg::COEF_W-1:0] coef_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [acpd_pkg::ACC_W-1:0] acc_o,
  output logic [ADC_BITS-1:0]               sample_o,
  output logic                              sat_o
);
  localparam int AW = acpd_pkg::ACC_W;
  localparam int PW = AW + ADC_BITS + 1;

  logic                 mul_v_q, add_v_q;
  logic signed [PW-1:0] prod_d, prod_q;
  logic [ADC_BITS-1:0]  mul_s_q, add_s_q;
  logic                 mul_sat_q, add_sat_q;
  logic signed [AW-1:0] acc_d, acc_q;
  logic                 sat_d;
  logic                 mul_rdy, add_rdy;
  logic signed [PW-1:0] shifted;
  logic signed [AW:0]   sum;

  assign add_rdy = !add_v_q || ready_i;
  assign mul_rdy = !mul_v_q || add_rdy;
  assign ready_o = mul_rdy;

  // acc times sample
  assign prod_d = PW'(acc_i) * $signed({1'b0, sample_i});

  // floor divide by 2^ADC_BITS, add coefficient, clamp to accumulator range
  always_comb begin
    shifted = prod_q >>> ADC_BITS;
    sum     = shifted[AW:0] + {{(AW+1-acpd_pkg::COEF_W){coef_i[acpd_pkg::COEF_W-1]}}, coef_i};
    acc_d   = sum[AW-1:0];
    sat_d   = mul_sat_q;
    if (sum[AW] != sum[AW-1]) begin
      sat_d = 1'b1;
      acc_d = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      add_v_q <= 1'b0;
    end else begin
      if (mul_rdy) mul_v_q <= valid_i;
      if (add_rdy) add_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && valid_i) begin
      prod_q    <= prod_d;
      mul_s_q   <= sample_i;
      mul_sat_q <= sat_i;
    end
    if (add_rdy && mul_v_q) begin
      acc_q     <= acc_d;
      add_s_q   <= mul_s_q;
      add_sat_q <= sat_d;
    end
  end

  assign valid_o  = add_v_q;
  assign acc_o    = acc_q;
  assign sample_o = add_s_q;
  assign sat_o    = add_sat_q;
endmodule

// ===== hw/rtl/acpd_div_step.sv =====
// One restoring-division stage: produces one quotient bit per register stage.
module acpd_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  acpd_pkg::div_data_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output acpd_pkg::div_data_t data_o
);
  localparam int DW = acpd_pkg::DIV_D_W;
  localparam int NW = acpd_pkg::DIV_N_W;

  logic                v_q;
  acpd_pkg::div_data_t dat_d, dat_q;
  logic [DW:0]         trial;
  logic                qbit;

  assign ready_o = !v_q || ready_i;

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    dat_d = data_i;
    trial = {data_i.rem[DW-1:0], data_i.work[NW-1]};
    qbit  = (trial >= {1'b0, data_i.dvs});
    dat_d.rem  = qbit ? (trial - {1'b0, data_i.dvs}) : trial;
    dat_d.work = {data_i.work[NW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) dat_q <= dat_d;
  end

  assign valid_o = v_q;
  assign data_o  = dat_q;
endmodule

// ===== hw/rtl/adc_poly_calibrate_divider.sv =====
// Top level: config registers, Horner pipeline, rounding, multiply, divider setup, divider pipeline, output stage.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | in_valid_i, in_ready_o, raw_sample_i      | in
//  result    | out_valid_o, out_ready_i, calibrated_count_o,
//            | resistance_ohms_o, divide_error_o, saturated_o | out
//  config    | cfg_we_i, cfg_index_i, cfg_data_i         | in
//
// One item enters per cycle while no stage stalls; the registers are, in order: two per Horner
// step (six steps), round, multiply, divider setup, one per quotient bit (43) and the output register.
// The 43-stage restoring divider sets the latency; throughput is one item per cycle unless the output stalls.
// Reset clears the valid bits and loads register defaults; no clearing pass.
// Each stage holds while its successor is full and stalled, so nothing is lost.
module adc_poly_calibrate_divider #(
  parameter int ADC_BITS       = acpd_pkg::ADC_BITS_DEF,
  parameter int ADC_FULL_SCALE = acpd_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ADC_BITS-1:0]                 raw_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [acpd_pkg::CNT_W-1:0]   calibrated_count_o,
  output logic signed [acpd_pkg::OHM_W-1:0]   resistance_ohms_o,
  output logic                                divide_error_o,
  output logic                                saturated_o,
  input  logic                                cfg_we_i,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [acpd_pkg::COEF_W-1:0]         cfg_data_i
);
  localparam int AW = acpd_pkg::ACC_W;
  localparam int CW = acpd_pkg::COEF_W;
  localparam int NC = acpd_pkg::NUM_COEFS;
  localparam int KW = acpd_pkg::CNT_W;
  localparam int PW = acpd_pkg::PROD_W;
  localparam int EW = acpd_pkg::DEN_W;
  localparam int NW = acpd_pkg::DIV_N_W;
  localparam int DW = acpd_pkg::DIV_D_W;
  localparam int OW = acpd_pkg::OHM_W;
  localparam int QW = AW - acpd_pkg::FRAC_W;

  // Configuration registers
  logic signed [CW-1:0]             coef_q [0:NC-1];
  logic [acpd_pkg::RES_W-1:0]       dres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NC; k++) begin
        coef_q[k] <= (k == NC - 2) ? acpd_pkg::COEF_DEG1_RST : '0;
      end
      dres_q <= acpd_pkg::DIV_RES_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == acpd_pkg::CFG_DIV_RES) begin
        dres_q <= cfg_data_i[acpd_pkg::RES_W-1:0];
      end else begin
        coef_q[cfg_index_i - acpd_pkg::CFG_COEF_DEG6] <= cfg_data_i;
      end
    end
  end

  // Horner pipeline
  logic                 h_v   [0:NC-1];
  logic                 h_rdy [0:NC-1];
  logic signed [AW-1:0] h_acc [0:NC-1];
  logic [ADC_BITS-1:0]  h_s   [0:NC-1];
  logic                 h_sat [0:NC-1];

  assign h_v[0]     = in_valid_i;
  assign in_ready_o = h_rdy[0];
  assign h_acc[0]   = {{(AW-CW){coef_q[0][CW-1]}}, coef_q[0]};
  assign h_s[0]     = raw_sample_i;
  assign h_sat[0]   = 1'b0;

  for (genvar k = 0; k < NC - 1; k++) begin : g_horner
    acpd_horner_step #(.ADC_BITS(ADC_BITS)) u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (h_v[k]),
      .ready_o  (h_rdy[k]),
      .acc_i    (h_acc[k]),
      .sample_i (h_s[k]),
      .sat_i    (h_sat[k]),
      .coef_i   (coef_q[k+1]),
      .valid_o  (h_v[k+1]),
      .ready_i  (h_rdy[k+1]),
      .acc_o    (h_acc[k+1]),
      .sample_o (h_s[k+1]),
      .sat_o    (h_sat[k+1])
    );
  end

  // Round Q.16 to nearest even and clamp to count range
  logic                 rn_v_q, rn_sat_q, rn_rdy, rn_sat_d;
  logic signed [KW-1:0] rn_cal_q, rn_cal_d;
  logic signed [QW-1:0] rq;
  logic signed [QW:0]   rqr;
  logic                 rup;

  always_comb begin
    rq       = h_acc[NC-1][AW-1:acpd_pkg::FRAC_W];
    rup      = h_acc[NC-1][acpd_pkg::FRAC_W-1] &&
               ((h_acc[NC-1][acpd_pkg::FRAC_W-2:0] != '0) || rq[0]);
    rqr      = {rq[QW-1], rq} + {{QW{1'b0}}, rup};
    rn_cal_d = rqr[KW-1:0];
    rn_sat_d = h_sat[NC-1];
    if (rqr[QW:KW-1] != {(QW-KW+2){rqr[QW]}}) begin
      rn_sat_d = 1'b1;
      rn_cal_d = rqr[QW] ? {1'b1, {(KW-1){1'b0}}} : {1'b0, {(KW-1){1'b1}}};
    end
  end

  // Multiply stage: cal * R and denominator
  logic                 pp_v_q, pp_sat_q, pp_rdy;
  logic signed [PW-1:0] pp_prod_q;
  logic signed [EW-1:0] pp_den_q;
  logic signed [KW-1:0] pp_cal_q;

  // Divider setup stage
  logic                 su_v_q, su_rdy;
  acpd_pkg::div_data_t  su_dat_q, su_dat_d;
  logic [PW-1:0]        pabs;
  logic [EW-1:0]        dabs;

  always_comb begin
    pabs          = pp_prod_q[PW-1] ? PW'(-pp_prod_q) : PW'(pp_prod_q);
    dabs          = pp_den_q[EW-1] ? EW'(-pp_den_q) : EW'(pp_den_q);
    su_dat_d.rem  = '0;
    su_dat_d.work = pabs[NW-1:0];
    su_dat_d.dvs  = dabs[DW-1:0];
    su_dat_d.neg  = pp_prod_q[PW-1] ^ pp_den_q[EW-1];
    su_dat_d.derr = (pp_den_q == '0);
    su_dat_d.sat  = pp_sat_q;
    su_dat_d.cal  = pp_cal_q;
  end

  // Divider pipeline
  logic                d_v   [0:NW];
  logic                d_rdy [0:NW];
  acpd_pkg::div_data_t d_dat [0:NW];

  assign d_v[0]   = su_v_q;
  assign d_dat[0] = su_dat_q;

  for (genvar b = 0; b < NW; b++) begin : g_div
    acpd_div_step u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d_v[b]),
      .ready_o (d_rdy[b]),
      .data_i  (d_dat[b]),
      .valid_o (d_v[b+1]),
      .ready_i (d_rdy[b+1]),
      .data_o  (d_dat[b+1])
    );
  end

  // Output stage: sign, clamp to int32, zero on divide error
  logic                 o_v_q, o_rdy;
  logic signed [KW-1:0] o_cal_q;
  logic signed [OW-1:0] o_res_q, o_res_d;
  logic                 o_derr_q, o_sat_q, o_sat_d;
  logic [NW-1:0]        fq;

  always_comb begin
    fq      = d_dat[NW].work;
    o_sat_d = d_dat[NW].sat;
    o_res_d = '0;
    if (!d_dat[NW].derr) begin
      if (d_dat[NW].neg) begin
        if (fq > {{(NW-OW){1'b0}}, 1'b1, {(OW-1){1'b0}}}) begin
          o_sat_d = 1'b1;
          o_res_d = {1'b1, {(OW-1){1'b0}}};
        end else begin
          o_res_d = OW'('0) - fq[OW-1:0];
        end
      end else if (fq > {{(NW-OW+1){1'b0}}, {(OW-1){1'b1}}}) begin
        o_sat_d = 1'b1;
        o_res_d = {1'b0, {(OW-1){1'b1}}};
      end else begin
        o_res_d = fq[OW-1:0];
      end
    end
  end

  // Stage handshakes
  assign o_rdy      = !o_v_q || out_ready_i;
  assign d_rdy[NW]  = o_rdy;
  assign su_rdy     = !su_v_q || d_rdy[0];
  assign pp_rdy     = !pp_v_q || su_rdy;
  assign rn_rdy     = !rn_v_q || pp_rdy;
  assign h_rdy[NC-1] = rn_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_v_q <= 1'b0;
      pp_v_q <= 1'b0;
      su_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (rn_rdy) rn_v_q <= h_v[NC-1];
      if (pp_rdy) pp_v_q <= rn_v_q;
      if (su_rdy) su_v_q <= pp_v_q;
      if (o_rdy)  o_v_q  <= d_v[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rn_rdy && h_v[NC-1]) begin
      rn_cal_q <= rn_cal_d;
      rn_sat_q <= rn_sat_d;
    end
    if (pp_rdy && rn_v_q) begin
      pp_prod_q <= PW'(rn_cal_q) * $signed({1'b0, dres_q});
      pp_den_q  <= EW'(ADC_FULL_SCALE) - EW'(rn_cal_q);
      pp_cal_q  <= rn_cal_q;
      pp_sat_q  <= rn_sat_q;
    end
    if (su_rdy && pp_v_q) begin
      su_dat_q <= su_dat_d;
    end
    if (o_rdy && d_v[NW]) begin
      o_cal_q  <= d_dat[NW].cal;
      o_res_q  <= o_res_d;
      o_derr_q <= d_dat[NW].derr;
      o_sat_q  <= o_sat_d;
    end
  end

  assign out_valid_o        = o_v_q;
  assign calibrated_count_o = o_cal_q;
  assign resistance_ohms_o  = o_res_q;
  assign divide_error_o     = o_derr_q;
  assign saturated_o        = o_sat_q;
endmodule
